@@ hdl/qack_pkg.sv @@
// ----------------------------------------------------------------------------
// QUIC ACK scheduler package
// Shared widths, codes, reset values and transaction types.
// ----------------------------------------------------------------------------
package qack_pkg;

   localparam int OP_W     = 2;
   localparam int PN_W     = 62;
   localparam int ECN_W    = 2;
   localparam int TIME_W   = 64;
   localparam int DELAY_W  = 24;
   localparam int EXP_W    = 5;
   localparam int THR_W    = 8;
   localparam int CNT_W    = 62;
   localparam int PEND_W   = 8;
   localparam int IDX_W    = 2;
   localparam int CSR_W    = 24;

   localparam logic [OP_W-1:0] OP_PACKET   = 2'd0;
   localparam logic [OP_W-1:0] OP_ACK_SENT = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY    = 2'd2;

   localparam logic [ECN_W-1:0] ECN_NONE = 2'd0;
   localparam logic [ECN_W-1:0] ECN_ECT1 = 2'd1;
   localparam logic [ECN_W-1:0] ECN_ECT0 = 2'd2;
   localparam logic [ECN_W-1:0] ECN_CE   = 2'd3;

   localparam logic [IDX_W-1:0] CSR_MAX_ACK_DELAY   = 2'd0;
   localparam logic [IDX_W-1:0] CSR_ACK_DELAY_EXP   = 2'd1;
   localparam logic [IDX_W-1:0] CSR_ELICIT_THRESH   = 2'd2;

   localparam logic [DELAY_W-1:0] MAX_ACK_DELAY_RST = 24'd25000;
   localparam logic [EXP_W-1:0]   ACK_DELAY_EXP_RST = 5'd3;
   localparam logic [THR_W-1:0]   ELICIT_THRESH_RST = 8'd2;
   localparam logic [EXP_W-1:0]   EXP_CAP           = 5'd20;

   typedef struct packed {
      logic [DELAY_W-1:0] ack_delay_limit;
      logic [EXP_W-1:0]   delay_shift;
      logic [THR_W-1:0]   eliciting_threshold;
   } cfg_type;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [PN_W-1:0]   packet_number;
      logic              is_app_level;
      logic              wants_ack;
      logic [ECN_W-1:0]  ecn_mark;
      logic [TIME_W-1:0] now_us;
   } req_type;

   typedef struct packed {
      logic              should_send;
      logic              ack_pending;
      logic [TIME_W-1:0] ack_deadline;
      logic [PN_W-1:0]   largest_received;
      logic [TIME_W-1:0] reported_delay;
      logic [CNT_W-1:0]  ect0_total;
      logic [CNT_W-1:0]  ect1_total;
      logic [CNT_W-1:0]  ce_total;
      logic              ecn_seen;
      logic              anything_received;
   } rsp_type;

endpackage

@@ hdl/qack_if.sv @@
// ----------------------------------------------------------------------------
// QUIC ACK scheduler channel interfaces
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface qack_req_if;
   logic                          valid;
   logic                          ready;
   logic [qack_pkg::OP_W-1:0]     opcode;
   logic [qack_pkg::PN_W-1:0]     packet_number;
   logic                          is_app_level;
   logic                          wants_ack;
   logic [qack_pkg::ECN_W-1:0]    ecn_mark;
   logic [qack_pkg::TIME_W-1:0]   now_us;

   modport source (output valid, opcode, packet_number, is_app_level, wants_ack,
                   ecn_mark, now_us, input ready);
   modport sink (input valid, opcode, packet_number, is_app_level, wants_ack,
                 ecn_mark, now_us, output ready);
endinterface

interface qack_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          should_send;
   logic                          ack_pending;
   logic [qack_pkg::TIME_W-1:0]   ack_deadline;
   logic [qack_pkg::PN_W-1:0]     largest_received;
   logic [qack_pkg::TIME_W-1:0]   reported_delay;
   logic [qack_pkg::CNT_W-1:0]    ect0_total;
   logic [qack_pkg::CNT_W-1:0]    ect1_total;
   logic [qack_pkg::CNT_W-1:0]    ce_total;
   logic                          ecn_seen;
   logic                          anything_received;

   modport source (output valid, should_send, ack_pending, ack_deadline, largest_received,
                   reported_delay, ect0_total, ect1_total, ce_total, ecn_seen,
                   anything_received, input ready);
   modport sink (input valid, should_send, ack_pending, ack_deadline, largest_received,
                 reported_delay, ect0_total, ect1_total, ce_total, ecn_seen,
                 anything_received, output ready);
endinterface

interface qack_csr_if;
   logic                          valid;
   logic                          ready;
   logic [qack_pkg::IDX_W-1:0]    index;
   logic [qack_pkg::CSR_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/qack_csr.sv @@
// ----------------------------------------------------------------------------
// QUIC ACK scheduler configuration registers
// Holds ack delay, delay exponent and eliciting threshold.
// ----------------------------------------------------------------------------
module qack_csr (
   input  logic              clock,
   input  logic              reset,
   qack_csr_if.sink          csr_bus,
   output qack_pkg::cfg_type cfg
);
   import qack_pkg::*;

   cfg_type cfg_ff;
   logic    wr_en;

   assign csr_bus.ready = 1'b1;
   assign wr_en         = csr_bus.valid;
   assign cfg           = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ack_delay_limit     <= MAX_ACK_DELAY_RST;
         cfg_ff.delay_shift         <= ACK_DELAY_EXP_RST;
         cfg_ff.eliciting_threshold <= ELICIT_THRESH_RST;
      end else if (wr_en) begin
         case (csr_bus.index)
            CSR_MAX_ACK_DELAY: cfg_ff.ack_delay_limit     <= csr_bus.data[DELAY_W-1:0];
            CSR_ACK_DELAY_EXP: cfg_ff.delay_shift         <= csr_bus.data[EXP_W-1:0];
            CSR_ELICIT_THRESH: cfg_ff.eliciting_threshold <= csr_bus.data[THR_W-1:0];
            default: ;
         endcase
      end
   end

endmodule

@@ hdl/qack_core.sv @@
// ----------------------------------------------------------------------------
// QUIC ACK scheduler state update
// Applies one transaction to the ACK state and forms its response.
// ----------------------------------------------------------------------------
module qack_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  qack_pkg::req_type req,
   input  qack_pkg::cfg_type cfg,
   output qack_pkg::rsp_type rsp
);
   import qack_pkg::*;

   logic              seen_ff, seen_in;
   logic [PN_W-1:0]   largest_ff, largest_in;
   logic [TIME_W-1:0] arrival_ff, arrival_in;
   logic [CNT_W-1:0]  ect0_ff, ect0_in;
   logic [CNT_W-1:0]  ect1_ff, ect1_in;
   logic [CNT_W-1:0]  ce_ff, ce_in;
   logic              ecn_ff, ecn_in;
   logic [PEND_W-1:0] pending_ff, pending_in;
   logic              immediate_ff, immediate_in;
   logic [TIME_W-1:0] deadline_ff, deadline_in;

   logic              is_pkt, is_ack, elicit, take_new, reordered, force_ack, arm;
   logic [PEND_W-1:0] pend_inc;
   logic [TIME_W:0]   sum;
   logic [TIME_W-1:0] sum_sat, keep_dl;
   logic              due, due_armed, zero_sum, dl_nz;
   logic [TIME_W:0]   diff;
   logic [TIME_W-1:0] held;
   logic [EXP_W-1:0]  shamt;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      sat_inc = (&v) ? v : v + CNT_W'(1);
   endfunction

   always_comb begin
      is_pkt    = (req.opcode == OP_PACKET);
      is_ack    = (req.opcode == OP_ACK_SENT);
      elicit    = is_pkt && req.wants_ack;
      reordered = seen_ff && (req.packet_number < largest_ff);
      take_new  = is_pkt && (!seen_ff || (req.packet_number > largest_ff));

      seen_in    = seen_ff | is_pkt;
      largest_in = take_new ? req.packet_number : largest_ff;
      arrival_in = take_new ? req.now_us : arrival_ff;

      ect0_in = (is_pkt && req.ecn_mark == ECN_ECT0) ? sat_inc(ect0_ff) : ect0_ff;
      ect1_in = (is_pkt && req.ecn_mark == ECN_ECT1) ? sat_inc(ect1_ff) : ect1_ff;
      ce_in   = (is_pkt && req.ecn_mark == ECN_CE)   ? sat_inc(ce_ff)   : ce_ff;
      ecn_in  = ecn_ff | (is_pkt && req.ecn_mark != ECN_NONE);

      pend_inc  = (&pending_ff) ? pending_ff : pending_ff + PEND_W'(1);
      force_ack = !req.is_app_level || reordered || (pend_inc >= cfg.eliciting_threshold);
      arm       = elicit && !force_ack && (deadline_ff == '0);

      sum      = {1'b0, req.now_us} + {{(TIME_W+1-DELAY_W){1'b0}}, cfg.ack_delay_limit};
      sum_sat  = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
      zero_sum = (req.now_us == '0) && (cfg.ack_delay_limit == '0);
      keep_dl  = is_ack ? '0 : deadline_ff;

      if (is_ack) begin
         pending_in   = '0;
         immediate_in = 1'b0;
      end else if (elicit) begin
         pending_in   = pend_inc;
         immediate_in = immediate_ff | force_ack;
      end else begin
         pending_in   = pending_ff;
         immediate_in = immediate_ff;
      end
      deadline_in = arm ? sum_sat : keep_dl;

      // a freshly armed deadline is due only when it equals now
      due_armed = !zero_sum && ((cfg.ack_delay_limit == '0) || (&req.now_us));
      dl_nz     = arm ? !zero_sum : (keep_dl != '0);
      due       = immediate_in ||
                  (arm ? due_armed : ((keep_dl != '0) && (req.now_us >= keep_dl)));

      diff  = {1'b0, req.now_us} - {1'b0, arrival_ff};
      held  = (!seen_in || take_new || diff[TIME_W]) ? '0 : diff[TIME_W-1:0];
      shamt = (cfg.delay_shift > EXP_CAP) ? EXP_CAP : cfg.delay_shift;

      rsp.should_send       = seen_in && due;
      rsp.ack_pending       = seen_in && (immediate_in || (pending_in != '0) || dl_nz);
      rsp.ack_deadline      = immediate_in ? TIME_W'(1) : deadline_in;
      rsp.largest_received  = largest_in;
      rsp.reported_delay    = held >> shamt;
      rsp.ect0_total        = ect0_in;
      rsp.ect1_total        = ect1_in;
      rsp.ce_total          = ce_in;
      rsp.ecn_seen          = ecn_in;
      rsp.anything_received = seen_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= 1'b0;
         largest_ff   <= '0;
         arrival_ff   <= '0;
         ect0_ff      <= '0;
         ect1_ff      <= '0;
         ce_ff        <= '0;
         ecn_ff       <= 1'b0;
         pending_ff   <= '0;
         immediate_ff <= 1'b0;
         deadline_ff  <= '0;
      end else if (step) begin
         seen_ff      <= seen_in;
         largest_ff   <= largest_in;
         arrival_ff   <= arrival_in;
         ect0_ff      <= ect0_in;
         ect1_ff      <= ect1_in;
         ce_ff        <= ce_in;
         ecn_ff       <= ecn_in;
         pending_ff   <= pending_in;
         immediate_ff <= immediate_in;
         deadline_ff  <= deadline_in;
      end
   end

endmodule

@@ hdl/quic_ack_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// QUIC ACK scheduler
// Decides when a QUIC receiver sends an ACK and reports ACK delay and ECN counts.
//
//   channel   modport  role
//   req_bus   sink     events: packet received, ACK sent, time query
//   rsp_bus   source   one response per request transaction
//   csr_bus   sink     register writes, always ready
//
// A request is registered on entry, then applied to the state and its response
// registered; one transaction per cycle while the response is not stalled.
// The throughput is set by the single state-update stage between the two registers.
// Reset clears the ACK state and the valid flags and loads register defaults.
// A stalled response holds its register; the input register still fills behind it.
// ----------------------------------------------------------------------------
module quic_ack_scheduler_top (
   input  logic      clock,
   input  logic      reset,
   qack_req_if.sink  req_bus,
   qack_rsp_if.source rsp_bus,
   qack_csr_if.sink  csr_bus
);
   import qack_pkg::*;

   cfg_type cfg;
   req_type in_data_ff, req_data;
   rsp_type out_data_ff, core_rsp;
   logic    in_valid_ff, in_valid_in;
   logic    out_valid_ff, out_valid_in;
   logic    advance, req_take;

   assign advance  = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_take = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !in_valid_ff || advance;

   assign req_data.opcode        = req_bus.opcode;
   assign req_data.packet_number = req_bus.packet_number;
   assign req_data.is_app_level  = req_bus.is_app_level;
   assign req_data.wants_ack     = req_bus.wants_ack;
   assign req_data.ecn_mark      = req_bus.ecn_mark;
   assign req_data.now_us        = req_bus.now_us;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_bus.ready);

   qack_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   qack_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .req   (in_data_ff),
      .cfg   (cfg),
      .rsp   (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= core_rsp;
      end
   end

   assign rsp_bus.valid             = out_valid_ff;
   assign rsp_bus.should_send       = out_data_ff.should_send;
   assign rsp_bus.ack_pending       = out_data_ff.ack_pending;
   assign rsp_bus.ack_deadline      = out_data_ff.ack_deadline;
   assign rsp_bus.largest_received  = out_data_ff.largest_received;
   assign rsp_bus.reported_delay    = out_data_ff.reported_delay;
   assign rsp_bus.ect0_total        = out_data_ff.ect0_total;
   assign rsp_bus.ect1_total        = out_data_ff.ect1_total;
   assign rsp_bus.ce_total          = out_data_ff.ce_total;
   assign rsp_bus.ecn_seen          = out_data_ff.ecn_seen;
   assign rsp_bus.anything_received = out_data_ff.anything_received;

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_bus.ready) |-> !req_bus.ready)
      else $error("request accepted while pipeline is full");

   a_send_needs_rx: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.should_send) |->
         (rsp_bus.anything_received && rsp_bus.ack_pending))
      else $error("ACK send without received packet or pending ACK");

   a_advance_fills_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_bus.valid)
      else $error("processed transaction lost before response register");

   a_no_rx_no_ecn: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.anything_received) |->
         (!rsp_bus.ecn_seen && rsp_bus.reported_delay == '0))
      else $error("ECN or delay reported before any packet");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// QUIC ACK scheduler testbench
// Drives packet, ACK-sent, time-query and unused-opcode transactions with random gaps on
// both channels and moves the registers through several settings. A
// scoreboard class predicts every response and checks it field by field.
// ----------------------------------------------------------------------------
module tb;
   import qack_pkg::*;

   localparam logic [OP_W-1:0]  OP_UNUSED      = 2'd3;
   localparam logic [IDX_W-1:0] CSR_UNUSED     = 2'd3;
   localparam int               WATCHDOG_LIMIT = 1000;
   localparam int               PRINT_LIMIT    = 40;

   class ack_schedule_checker;
      cfg_type          cfg;
      logic             seen;
      logic [PN_W-1:0]  largest_pn;
      logic [TIME_W-1:0] largest_at;
      logic [CNT_W-1:0] ect0_count;
      logic [CNT_W-1:0] ect1_count;
      logic [CNT_W-1:0] ce_count;
      logic             ecn_flag;
      logic [PEND_W-1:0] pending;
      logic             immediate;
      logic [TIME_W-1:0] deadline;
      rsp_type          expected_acks[$];
      int               errors;

      function new();
         cfg.ack_delay_limit     = MAX_ACK_DELAY_RST;
         cfg.delay_shift         = ACK_DELAY_EXP_RST;
         cfg.eliciting_threshold = ELICIT_THRESH_RST;
         seen       = 1'b0;
         largest_pn = '0;
         largest_at = '0;
         ect0_count = '0;
         ect1_count = '0;
         ce_count   = '0;
         ecn_flag   = 1'b0;
         pending    = '0;
         immediate  = 1'b0;
         deadline   = '0;
         errors     = 0;
      endfunction

      function void write_register(logic [IDX_W-1:0] idx, logic [CSR_W-1:0] data);
         case (idx)
            CSR_MAX_ACK_DELAY: cfg.ack_delay_limit     = data[DELAY_W-1:0];
            CSR_ACK_DELAY_EXP: cfg.delay_shift         = data[EXP_W-1:0];
            CSR_ELICIT_THRESH: cfg.eliciting_threshold = data[THR_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
         return (&v) ? v : v + 1'b1;
      endfunction

      function void predict_ack(req_type r);
         logic              reordered;
         logic [TIME_W:0]   sum;
         logic [TIME_W-1:0] held;
         logic [EXP_W-1:0]  shift;
         logic              due;
         rsp_type           e;
         case (r.opcode)
            OP_PACKET: begin
               reordered = seen && (r.packet_number < largest_pn);
               if (!seen || r.packet_number > largest_pn) begin
                  largest_pn = r.packet_number;
                  largest_at = r.now_us;
               end
               seen = 1'b1;
               case (r.ecn_mark)
                  ECN_ECT0: begin
                     ect0_count = bump(ect0_count);
                     ecn_flag   = 1'b1;
                  end
                  ECN_ECT1: begin
                     ect1_count = bump(ect1_count);
                     ecn_flag   = 1'b1;
                  end
                  ECN_CE: begin
                     ce_count = bump(ce_count);
                     ecn_flag = 1'b1;
                  end
                  default: ;
               endcase
               if (r.wants_ack) begin
                  if (pending != 8'hFF) pending = pending + 1'b1;
                  if (!r.is_app_level || reordered || pending >= cfg.eliciting_threshold) begin
                     immediate = 1'b1;
                  end else if (deadline == '0) begin
                     sum = {1'b0, r.now_us} + {{(TIME_W+1-DELAY_W){1'b0}}, cfg.ack_delay_limit};
                     deadline = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                  end
               end
            end
            OP_ACK_SENT: begin
               pending   = '0;
               deadline  = '0;
               immediate = 1'b0;
            end
            default: ;
         endcase
         due   = immediate || (deadline != '0 && r.now_us >= deadline);
         held  = (seen && r.now_us > largest_at) ? r.now_us - largest_at : '0;
         shift = (cfg.delay_shift > EXP_CAP) ? EXP_CAP : cfg.delay_shift;
         e.should_send       = seen && due;
         e.ack_pending       = seen && (immediate || pending != '0 || deadline != '0);
         e.ack_deadline      = immediate ? 64'd1 : deadline;
         e.largest_received  = largest_pn;
         e.reported_delay    = held >> shift;
         e.ect0_total        = ect0_count;
         e.ect1_total        = ect1_count;
         e.ce_total          = ce_count;
         e.ecn_seen          = ecn_flag;
         e.anything_received = seen;
         expected_acks.push_back(e);
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         errors++;
         if (errors <= PRINT_LIMIT)
            $display("mismatch on %s: got %h, expected %h", what, got, want);
      endtask

      task check_ack(rsp_type got);
         rsp_type want;
         if (expected_acks.size() == 0) begin
            report("response with none outstanding", 64'd0, 64'd0);
            return;
         end
         want = expected_acks.pop_front();
         if (got.should_send !== want.should_send)
            report("should_send", got.should_send, want.should_send);
         if (got.ack_pending !== want.ack_pending)
            report("ack_pending", got.ack_pending, want.ack_pending);
         if (got.ack_deadline !== want.ack_deadline)
            report("ack_deadline", got.ack_deadline, want.ack_deadline);
         if (got.largest_received !== want.largest_received)
            report("largest_received", got.largest_received, want.largest_received);
         if (got.reported_delay !== want.reported_delay)
            report("reported_delay", got.reported_delay, want.reported_delay);
         if (got.ect0_total !== want.ect0_total)
            report("ect0_total", got.ect0_total, want.ect0_total);
         if (got.ect1_total !== want.ect1_total)
            report("ect1_total", got.ect1_total, want.ect1_total);
         if (got.ce_total !== want.ce_total)
            report("ce_total", got.ce_total, want.ce_total);
         if (got.ecn_seen !== want.ecn_seen)
            report("ecn_seen", got.ecn_seen, want.ecn_seen);
         if (got.anything_received !== want.anything_received)
            report("anything_received", got.anything_received, want.anything_received);
      endtask
   endclass

   logic                clock;
   logic                reset;
   logic [TIME_W-1:0]   event_time;
   bit                  no_idle;
   int                  idle_cycles;
   ack_schedule_checker sb;

   qack_req_if req_bus ();
   qack_rsp_if rsp_bus ();
   qack_csr_if csr_bus ();

   quic_ack_scheduler_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #4 clock = ~clock;

   function automatic int unsigned pick_gap();
      return no_idle ? 0 : $urandom_range(0, 19);
   endfunction

   task automatic issue_request(input logic [OP_W-1:0] op, input logic [PN_W-1:0] pn,
                                input logic app, input logic elic,
                                input logic [ECN_W-1:0] ecn, input logic [TIME_W-1:0] now);
      req_type     r;
      int unsigned gap;
      gap = pick_gap();
      r.opcode        = op;
      r.packet_number = pn;
      r.is_app_level  = app;
      r.wants_ack     = elic;
      r.ecn_mark      = ecn;
      r.now_us        = now;
      @(negedge clock);
      if (gap != 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.opcode        = r.opcode;
      req_bus.packet_number = r.packet_number;
      req_bus.is_app_level  = r.is_app_level;
      req_bus.wants_ack     = r.wants_ack;
      req_bus.ecn_mark      = r.ecn_mark;
      req_bus.now_us        = r.now_us;
      req_bus.valid         = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      sb.predict_ack(r);
   endtask

   task automatic drain();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (sb.expected_acks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_bus.index = idx;
      csr_bus.data  = data;
      csr_bus.valid = 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      sb.write_register(idx, data);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic configure(input logic [DELAY_W-1:0] delay, input logic [EXP_W-1:0] exp_shift,
                            input logic [THR_W-1:0] thr);
      logic [31:0] noise;
      noise = $urandom;
      drain();
      write_register(CSR_MAX_ACK_DELAY, delay);
      write_register(CSR_ACK_DELAY_EXP, {noise[CSR_W-1:EXP_W], exp_shift});
      write_register(CSR_ELICIT_THRESH, {noise[CSR_W-THR_W-1:0], thr});
   endtask

   task automatic send_random_event(input bit packets_only);
      int unsigned       roll;
      int unsigned       span;
      logic [OP_W-1:0]   op;
      logic [63:0]       full;
      logic [PN_W-1:0]   pn;
      logic              app;
      logic              elic;
      logic [ECN_W-1:0]  ecn;
      roll = $urandom_range(0, 99);
      if (packets_only || roll < 60) op = OP_PACKET;
      else if (roll < 74)            op = OP_ACK_SENT;
      else if (roll < 94)            op = OP_QUERY;
      else                           op = OP_UNUSED;
      full = {$urandom, $urandom};
      pn   = full[PN_W-1:0];
      roll = $urandom_range(0, 99);
      if (packets_only || roll < 68) pn = sb.largest_pn + $urandom_range(1, 4);
      else if (roll < 80)            pn = sb.largest_pn - $urandom_range(1, 8);
      else if (roll < 87)            pn = sb.largest_pn;
      else if (roll < 89)            pn = '0;
      else if (roll < 91)            pn = '1;
      app  = packets_only || ($urandom_range(0, 99) < 85);
      elic = packets_only || ($urandom_range(0, 99) < 70);
      ecn  = ECN_W'($urandom_range(0, 3));
      span = sb.cfg.ack_delay_limit;
      roll = $urandom_range(0, 99);
      if (roll < 30)      event_time = event_time + $urandom_range(0, 3);
      else if (roll < 80) event_time = event_time + $urandom_range(0, span / 8 + 8);
      else if (roll < 92) event_time = event_time + span + $urandom_range(0, 2) - 1;
      else if (roll < 96) event_time = event_time - $urandom_range(0, 2000);
      else if (roll < 98) event_time = {$urandom, $urandom};
      else                event_time = '1 - $urandom_range(0, 3);
      issue_request(op, pn, app, elic, ecn, event_time);
   endtask

   // response side
   initial begin
      int unsigned gap;
      rsp_type     got;
      rsp_bus.ready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         gap = pick_gap();
         @(negedge clock);
         if (gap != 0) begin
            rsp_bus.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         got.should_send       = rsp_bus.should_send;
         got.ack_pending       = rsp_bus.ack_pending;
         got.ack_deadline      = rsp_bus.ack_deadline;
         got.largest_received  = rsp_bus.largest_received;
         got.reported_delay    = rsp_bus.reported_delay;
         got.ect0_total        = rsp_bus.ect0_total;
         got.ect1_total        = rsp_bus.ect1_total;
         got.ce_total          = rsp_bus.ce_total;
         got.ecn_seen          = rsp_bus.ecn_seen;
         got.anything_received = rsp_bus.anything_received;
         sb.check_ack(got);
      end
   end

   // watchdog
   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      clock                 = 1'b0;
      reset                 = 1'b1;
      no_idle               = 1'b0;
      event_time            = '0;
      req_bus.valid         = 1'b0;
      req_bus.opcode        = OP_QUERY;
      req_bus.packet_number = '0;
      req_bus.is_app_level  = 1'b0;
      req_bus.wants_ack     = 1'b0;
      req_bus.ecn_mark      = ECN_NONE;
      req_bus.now_us        = '0;
      csr_bus.valid         = 1'b0;
      csr_bus.index         = CSR_MAX_ACK_DELAY;
      csr_bus.data          = '0;
      sb = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed, register defaults
      issue_request(OP_QUERY, 62'd0, 1'b1, 1'b1, ECN_NONE, 64'd0);
      issue_request(OP_ACK_SENT, '1, 1'b0, 1'b0, ECN_CE, 64'd50);
      issue_request(OP_UNUSED, 62'h1555_5555_5555_5555, 1'b1, 1'b1, ECN_ECT0, 64'd60);
      issue_request(OP_PACKET, 62'd5, 1'b1, 1'b1, ECN_NONE, 64'd100);
      issue_request(OP_QUERY, 62'd0, 1'b0, 1'b0, ECN_NONE, 64'd25099);
      issue_request(OP_QUERY, 62'd0, 1'b0, 1'b0, ECN_NONE, 64'd25100);
      issue_request(OP_PACKET, 62'd3, 1'b1, 1'b1, ECN_ECT1, 64'd25200);
      issue_request(OP_ACK_SENT, 62'd0, 1'b0, 1'b0, ECN_NONE, 64'd25300);
      issue_request(OP_PACKET, 62'd5, 1'b1, 1'b1, ECN_ECT0, 64'd25400);
      issue_request(OP_PACKET, 62'd6, 1'b1, 1'b0, ECN_CE, 64'd25500);
      issue_request(OP_PACKET, 62'd7, 1'b0, 1'b1, ECN_NONE, 64'd25600);
      issue_request(OP_ACK_SENT, 62'd0, 1'b0, 1'b0, ECN_NONE, 64'd25700);
      issue_request(OP_QUERY, 62'd0, 1'b0, 1'b0, ECN_NONE, 64'd10);
      issue_request(OP_PACKET, '1, 1'b1, 1'b1, ECN_ECT0, '1);
      issue_request(OP_QUERY, 62'd0, 1'b0, 1'b0, ECN_NONE, '1);
      issue_request(OP_UNUSED, 62'h2AAA_AAAA_AAAA_AAAA, 1'b0, 1'b1, ECN_ECT1, '1);
      issue_request(OP_ACK_SENT, 62'd0, 1'b1, 1'b0, ECN_NONE, 64'd0);

      // zero delay: a deadline sum of zero arms nothing
      configure(24'd0, 5'd0, 8'd2);
      issue_request(OP_PACKET, '1, 1'b1, 1'b1, ECN_NONE, 64'd0);
      issue_request(OP_QUERY, 62'd0, 1'b0, 1'b0, ECN_NONE, 64'd0);
      issue_request(OP_ACK_SENT, 62'd0, 1'b0, 1'b0, ECN_NONE, 64'd5);

      // zero threshold forces an immediate ACK
      configure(24'd0, 5'd0, 8'd0);
      issue_request(OP_PACKET, '1, 1'b1, 1'b1, ECN_NONE, 64'd7);
      issue_request(OP_PACKET, 62'd0, 1'b1, 1'b0, ECN_ECT1, 64'd8);
      issue_request(OP_ACK_SENT, 62'd0, 1'b0, 1'b0, ECN_NONE, 64'd9);

      event_time = 64'd1000;
      for (int phase = 0; phase < 9; phase++) begin
         case (phase)
            0: configure(24'd16383000, 5'd20, 8'd255);
            1: configure(24'hFFFFFF, 5'd31, 8'd1);
            2: configure(24'd1, 5'd0, 8'd0);
            3: configure(24'd0, 5'd5, 8'd3);
            default: configure(DELAY_W'(($urandom_range(0, 3) == 0) ? $urandom
                                                                   : $urandom_range(0, 60000)),
                               EXP_W'($urandom_range(0, 31)),
                               THR_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                                  : $urandom_range(0, 6)));
         endcase
         if (phase == 1) write_register(CSR_UNUSED, CSR_W'($urandom));
         // hold back ACKs long enough to saturate the pending count
         if (phase == 0) begin
            for (int n = 0; n < 280; n++) send_random_event(1'b1);
         end
         for (int n = 0; n < 130; n++) begin
            if (n % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) == 0) drain();
            send_random_event(1'b0);
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.expected_acks.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
